// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the symmetric FIR block.
// Included by name from the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== sv/sfe_pkg.sv =====
// Package for the symmetric FIR with edge clamping: payload structs, control
// structs and fixed constants. No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sfe_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 16;
   localparam int PRE_W     = SAMPLE_W + 1;
   localparam int PROD_W    = PRE_W + COEF_W;
   localparam int RADIUS_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int FRAC_BITS  = 14;
   localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);
   localparam int SAT_MAX    = 32767;
   localparam int SAT_MIN    = -32768;

   // Register indexes of the configuration port.
   localparam int CSR_RADIUS = 0;
   localparam int CSR_TAP0   = 1;

   localparam logic [RADIUS_W-1:0]      RADIUS_RESET = 3'd1;
   localparam logic signed [COEF_W-1:0] TAP0_RESET   = 16'sh4000;

   // Output queue.
   localparam int OQ_DEPTH = 8;
   localparam int OQ_AW    = 3;
   localparam int OQ_CNT_W = 4;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       line_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       last_of_line;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
   } win_ctl_type;

   typedef struct packed {
      logic emit;
      logic last;
   } stage_ctl_type;

endpackage

`default_nettype wire

// ===== sv/sfe_cell.sv =====
// One cell of the sample window: holds one sample, loads it or takes the
// neighbor's sample. Depends on sfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfe_cell (
   input  logic                                 clock,
   input  sfe_pkg::win_ctl_type                 ctl,
   input  logic signed [sfe_pkg::SAMPLE_W-1:0]  load_sample,
   input  logic signed [sfe_pkg::SAMPLE_W-1:0]  prev_sample,
   output logic signed [sfe_pkg::SAMPLE_W-1:0]  sample
);

   logic signed [sfe_pkg::SAMPLE_W-1:0] sample_ff;
   logic signed [sfe_pkg::SAMPLE_W-1:0] sample_in;

   always_comb begin
      sample_in = sample_ff;
      if (ctl.load) begin
         sample_in = load_sample;
      end else if (ctl.shift) begin
         sample_in = prev_sample;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign sample = sample_ff;

endmodule

`default_nettype wire

// ===== sv/sfe_tap.sv =====
// One tap lane: picks the sample pair at distance DIST around the current
// center, pre-adds it and multiplies by the coefficient. Depends on sfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfe_tap #(
   parameter int MAX_RADIUS = 6,
   parameter int DIST       = 0
) (
   input  logic                                  clock,
   input  logic signed [sfe_pkg::SAMPLE_W-1:0]   win [0:2*MAX_RADIUS],
   input  logic [$clog2(MAX_RADIUS+1)-1:0]       radius,
   input  logic signed [sfe_pkg::COEF_W-1:0]     coef,
   output logic signed [sfe_pkg::PROD_W-1:0]     prod
);

   localparam int SW = sfe_pkg::SAMPLE_W;

   logic signed [SW-1:0]                 near_s;
   logic signed [SW-1:0]                 far_s;
   logic signed [sfe_pkg::PRE_W-1:0]     pre_in;
   logic signed [sfe_pkg::PRE_W-1:0]     pre_ff;
   logic signed [sfe_pkg::PROD_W-1:0]    prod_in;
   logic signed [sfe_pkg::PROD_W-1:0]    prod_ff;

   // The center sits at window position radius; a lane beyond the radius
   // contributes nothing.
   always_comb begin
      near_s = '0;
      far_s  = '0;
      for (int m = DIST; m <= MAX_RADIUS; m++) begin
         if (int'(radius) == m) begin
            near_s = win[m - DIST];
            far_s  = win[m + DIST];
         end
      end
      if (DIST == 0) begin
         pre_in = {near_s[SW-1], near_s};
      end else begin
         pre_in = {near_s[SW-1], near_s} + {far_s[SW-1], far_s};
      end
   end

   assign prod_in = pre_ff * coef;

   always_ff @(posedge clock) begin
      pre_ff  <= pre_in;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== sv/sfe_sum.sv =====
// Registered adder tree over the tap products, then rounding away the 14 fraction
// bits of the Q1.14 coefficients and saturation to 16 bits. Depends on sfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfe_sum #(
   parameter int MAX_RADIUS = 6
) (
   input  logic                                 clock,
   input  logic signed [sfe_pkg::PROD_W-1:0]    prod [0:MAX_RADIUS],
   output logic signed [sfe_pkg::SAMPLE_W-1:0]  filtered
);

   localparam int NL    = MAX_RADIUS + 1;
   localparam int NG    = (NL + 3) / 4;
   localparam int GRP_W = sfe_pkg::PROD_W + 2;
   localparam int ACC_W = GRP_W + $clog2(NG) + 1;
   localparam int SW    = sfe_pkg::SAMPLE_W;

   logic signed [sfe_pkg::PROD_W-1:0] prod_pad [0:NG*4-1];
   logic signed [GRP_W-1:0]           grp_in   [0:NG-1];
   logic signed [GRP_W-1:0]           grp_ff   [0:NG-1];
   logic signed [ACC_W-1:0]           acc;
   logic signed [ACC_W-1:0]           shifted;

   genvar gi;
   for (gi = 0; gi < NG*4; gi++) begin : g_pad
      if (gi < NL) begin : g_lane
         assign prod_pad[gi] = prod[gi];
      end else begin : g_zero
         assign prod_pad[gi] = '0;
      end
   end

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = GRP_W'(prod_pad[g*4]) + GRP_W'(prod_pad[g*4+1])
                   + GRP_W'(prod_pad[g*4+2]) + GRP_W'(prod_pad[g*4+3]);
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   // Round half up, then floor by an arithmetic shift.
   always_comb begin
      acc = ACC_W'(sfe_pkg::ROUND_BIAS);
      for (int g = 0; g < NG; g++) begin
         acc = acc + ACC_W'(grp_ff[g]);
      end
      shifted = acc >>> sfe_pkg::FRAC_BITS;
      if (shifted > ACC_W'(sfe_pkg::SAT_MAX)) begin
         filtered = SW'(sfe_pkg::SAT_MAX);
      end else if (shifted < ACC_W'(sfe_pkg::SAT_MIN)) begin
         filtered = SW'(sfe_pkg::SAT_MIN);
      end else begin
         filtered = shifted[SW-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== sv/sfe_outq.sv =====
// Result queue between the filter pipeline and the result channel.
// Depends on sfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfe_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sfe_pkg::rsp_type  push_item,
   input  logic              out_stall,
   output logic              out_valid,
   output sfe_pkg::rsp_type  out_item
);

   localparam int AW = sfe_pkg::OQ_AW;
   localparam int CW = sfe_pkg::OQ_CNT_W;

   sfe_pkg::rsp_type queue_ff [0:sfe_pkg::OQ_DEPTH-1];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && !out_stall;
   assign out_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/symmetric_fir_edge_clamped.sv =====
// Symmetric FIR over lines of samples with edge replication at both ends.
// Input channel (req_valid, req_stall, req_data): one sample per transfer,
// req_data.line_end marks the last sample of a line. Result channel
// (rsp_valid, rsp_stall, rsp_data): filtered samples (Q1.14 coefficients), last_of_line set
// on the final result of each line. Configuration: csr_we writes csr_wdata
// into register csr_index (0 radius, 1 + k tap k coefficient).
// Throughput: one sample per cycle while req_stall is low. A line_end sample holds req_stall
// high while the window is flushed with the last sample.
// Pipeline: a result passes the window cells, the pre-add and product registers
// of the tap lanes and the group-sum register on its way into the output queue;
// the output for position i waits for sample i+radius.
// Stall: results collect in an 8-entry queue; apart from a flush, the input stalls
// only while queued plus in-flight results fill it, so a stalled receiver does not stop
// input until the queue is full.
// Reset: radius 1, center coefficient 1.0, side coefficients 0, queue empty,
// and the next sample starts a new line.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module symmetric_fir_edge_clamped #(
   parameter int MAX_RADIUS = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  sfe_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output sfe_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [$clog2(MAX_RADIUS+2)-1:0]       csr_index,
   input  logic [sfe_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int WIN_LEN = 2 * MAX_RADIUS + 1;
   localparam int R_W     = $clog2(MAX_RADIUS + 1);
   localparam int SEEN_W  = $clog2(MAX_RADIUS + 2);
   localparam int SW      = sfe_pkg::SAMPLE_W;
   localparam int CW      = sfe_pkg::OQ_CNT_W;

   // Configuration registers.
   logic [sfe_pkg::RADIUS_W-1:0]      radius_ff, radius_in;
   logic signed [sfe_pkg::COEF_W-1:0] coef_ff [0:MAX_RADIUS];
   logic signed [sfe_pkg::COEF_W-1:0] coef_in [0:MAX_RADIUS];
   logic [R_W-1:0]                    eff_r;

   // Line sequencing.
   logic              line_start_ff, line_start_in;
   logic [SEEN_W-1:0] seen_ff, seen_in, seen_new;
   logic              flush_ff, flush_in;
   logic [R_W-1:0]    flush_j_ff, flush_j_in;
   logic [CW-1:0]     occ_ff, occ_in;
   logic              room;
   logic              take;
   logic              flush_step;
   logic              pop;

   // Window and pipeline.
   sfe_pkg::win_ctl_type    win_ctl;
   logic signed [SW-1:0]    shift_val;
   logic signed [SW-1:0]    win       [0:WIN_LEN-1];
   logic signed [SW-1:0]    cell_prev [0:WIN_LEN-1];
   logic signed [sfe_pkg::PROD_W-1:0] prod [0:MAX_RADIUS];
   logic signed [SW-1:0]    filtered;
   sfe_pkg::stage_ctl_type  s0_ctl_in, s0_ctl_ff, s1_ctl_ff, s2_ctl_ff, s3_ctl_ff;
   sfe_pkg::rsp_type        push_item;

   // ---------------------------------------------------------------------
   // Configuration port. Radius values above MAX_RADIUS act as MAX_RADIUS.
   // ---------------------------------------------------------------------
   always_comb begin
      radius_in = radius_ff;
      coef_in   = coef_ff;
      if (csr_we) begin
         if (int'(csr_index) == sfe_pkg::CSR_RADIUS) begin
            radius_in = csr_wdata[sfe_pkg::RADIUS_W-1:0];
         end
         for (int k = 0; k <= MAX_RADIUS; k++) begin
            if (int'(csr_index) == sfe_pkg::CSR_TAP0 + k) begin
               coef_in[k] = csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= sfe_pkg::RADIUS_RESET;
         for (int k = 0; k <= MAX_RADIUS; k++) begin
            coef_ff[k] <= (k == 0) ? sfe_pkg::TAP0_RESET : '0;
         end
      end else begin
         radius_ff <= radius_in;
         coef_ff   <= coef_in;
      end
   end

   assign eff_r = (int'(radius_ff) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(radius_ff);

   // ---------------------------------------------------------------------
   // Sequencer. Every cycle the window takes at most one step: a load of
   // the whole window with the first sample of a line, a shift of a new
   // sample, or a flush shift that repeats the newest sample. Each step
   // that completes a window issues one result into the pipeline. A step
   // is only taken when the output queue has room for everything in flight.
   // ---------------------------------------------------------------------
   assign room       = (int'(occ_ff) < sfe_pkg::OQ_DEPTH);
   assign req_stall  = flush_ff || !room;
   assign take       = req_valid && !req_stall;
   assign flush_step = flush_ff && room;
   assign pop        = rsp_valid && !rsp_stall;

   always_comb begin
      if (line_start_ff) begin
         seen_new = SEEN_W'(1);
      end else if (int'(seen_ff) == MAX_RADIUS + 1) begin
         seen_new = seen_ff;
      end else begin
         seen_new = seen_ff + SEEN_W'(1);
      end
   end

   always_comb begin
      win_ctl       = '0;
      s0_ctl_in     = '0;
      line_start_in = line_start_ff;
      seen_in       = seen_ff;
      flush_in      = flush_ff;
      flush_j_in    = flush_j_ff;
      if (take) begin
         win_ctl.load   = line_start_ff;
         win_ctl.shift  = !line_start_ff;
         s0_ctl_in.emit = (int'(seen_new) >= int'(eff_r) + 1);
         s0_ctl_in.last = req_data.line_end && (eff_r == '0);
         seen_in        = seen_new;
         line_start_in  = req_data.line_end;
         flush_in       = req_data.line_end && (eff_r != '0);
         flush_j_in     = R_W'(1);
      end else if (flush_step) begin
         win_ctl.shift  = 1'b1;
         s0_ctl_in.emit = (int'(flush_j_ff) + int'(seen_ff) >= int'(eff_r) + 1);
         s0_ctl_in.last = (flush_j_ff == eff_r);
         flush_in       = (flush_j_ff != eff_r);
         flush_j_in     = flush_j_ff + R_W'(1);
      end
   end

   assign occ_in = occ_ff + CW'(s0_ctl_in.emit) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_ff <= 1'b1;
         seen_ff       <= '0;
         flush_ff      <= 1'b0;
         flush_j_ff    <= '0;
         occ_ff        <= '0;
         s0_ctl_ff     <= '0;
         s1_ctl_ff     <= '0;
         s2_ctl_ff     <= '0;
         s3_ctl_ff     <= '0;
      end else begin
         line_start_ff <= line_start_in;
         seen_ff       <= seen_in;
         flush_ff      <= flush_in;
         flush_j_ff    <= flush_j_in;
         occ_ff        <= occ_in;
         s0_ctl_ff     <= s0_ctl_in;
         s1_ctl_ff     <= s0_ctl_ff;
         s2_ctl_ff     <= s1_ctl_ff;
         s3_ctl_ff     <= s2_ctl_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Window: a chain of cells, newest sample in cell 0. A flush feeds
   // cell 0 its own sample back, which replicates the right edge.
   // ---------------------------------------------------------------------
   assign shift_val = flush_ff ? win[0] : req_data.sample;

   genvar ci;
   for (ci = 0; ci < WIN_LEN; ci++) begin : g_cell
      if (ci == 0) begin : g_head
         assign cell_prev[ci] = shift_val;
      end else begin : g_link
         assign cell_prev[ci] = win[ci-1];
      end
      sfe_cell u_cell (
         .clock       (clock),
         .ctl         (win_ctl),
         .load_sample (req_data.sample),
         .prev_sample (cell_prev[ci]),
         .sample      (win[ci])
      );
   end

   // Tap lanes: pre-add and multiply, two register stages.
   genvar ti;
   for (ti = 0; ti <= MAX_RADIUS; ti++) begin : g_tap
      sfe_tap #(
         .MAX_RADIUS (MAX_RADIUS),
         .DIST       (ti)
      ) u_tap (
         .clock  (clock),
         .win    (win),
         .radius (eff_r),
         .coef   (coef_ff[ti]),
         .prod   (prod[ti])
      );
   end

   // Adder tree, rounding and saturation; the result is written to the queue.
   sfe_sum #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_sum (
      .clock    (clock),
      .prod     (prod),
      .filtered (filtered)
   );

   always_comb begin
      push_item.filtered     = filtered;
      push_item.last_of_line = s3_ctl_ff.last;
   end

   sfe_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_ctl_ff.emit),
      .push_item (push_item),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_item  (rsp_data)
   );

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   `ASSERT_CLK(a_occ_bound, clock, reset, occ_ff <= CW'(sfe_pkg::OQ_DEPTH), "result count exceeds queue depth")
   `ASSERT_NEVER(a_queue_counted, clock, reset, rsp_valid && (occ_ff == '0), "queued result not counted")
   `ASSERT_CLK(a_flush_ends_emit, clock, reset, (flush_step && (flush_j_ff == eff_r)) |-> s0_ctl_in.emit, "final flush step issued no result")
   `ASSERT_CLK(a_last_ends_line, clock, reset, (s0_ctl_in.emit && s0_ctl_in.last) |=> (line_start_ff && !flush_ff), "line did not close after its last result")

endmodule

`default_nettype wire
